@@ rtl/heightmap_neighbour_smoother_top_macros.svh @@
// assertion helpers, compiled out for synthesis
`ifndef HEIGHTMAP_NEIGHBOUR_SMOOTHER_TOP_MACROS_SVH
`define HEIGHTMAP_NEIGHBOUR_SMOOTHER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define HNS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("hns assertion failed");

// next-cycle implication
`define HNS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("hns assertion failed");

`else

`define HNS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define HNS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/hns_pkg.sv @@
package hns_pkg;

    localparam int CFG_W      = 11;
    localparam int POS_W      = 10;
    localparam int RESET_SIDE = 256;

    // divisor for one average
    typedef enum logic [1:0] {
        DIV2,
        DIV3,
        DIV4
    } t_div;

    // result slot within one word's group of results
    typedef enum logic [1:0] {
        LANE_PREV,
        LANE_LEFT,
        LANE_FINAL
    } t_lane;

    // which neighbours exist for the cells touched by one input word
    typedef struct packed {
        logic up;
        logic left;
        logic right;
        logic left2;
        logic has2;
        logic has3;
    } t_nbr;

endpackage

@@ rtl/hns_linebuf.sv @@
module hns_linebuf #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 24
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_swap,
    input  logic [$clog2(DEPTH)-1:0] i_col,
    input  logic [$clog2(DEPTH)-1:0] i_addr_a,
    input  logic [$clog2(DEPTH)-1:0] i_addr_b,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_prev_a,
    output logic [WIDTH-1:0]         o_prev_b,
    output logic [WIDTH-1:0]         o_older
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem0 [DEPTH];
    logic [WIDTH-1:0] r_mem1 [DEPTH];
    logic [WIDTH-1:0] r_rd0_a, r_rd0_b, r_rd1_a, r_rd1_b;
    logic             r_bank;
    logic             r_sel;
    logic [AW-1:0]    addr0, addr1;

    // bank 0 set: mem0 holds the previous row, mem1 the older row plus current samples
    assign addr0 = r_bank ? i_col : i_addr_a;
    assign addr1 = r_bank ? i_addr_a : i_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank <= 1'b0;
        end else if (i_en && i_swap) begin
            r_bank <= ~r_bank;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sel <= r_bank;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rd0_a <= r_mem0[addr0];
            r_rd0_b <= r_mem0[i_addr_b];
            if (r_bank) begin
                r_mem0[i_col] <= i_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rd1_a <= r_mem1[addr1];
            r_rd1_b <= r_mem1[i_addr_b];
            if (!r_bank) begin
                r_mem1[i_col] <= i_wdata;
            end
        end
    end

    assign o_prev_a = r_sel ? r_rd1_a : r_rd0_a;
    assign o_prev_b = r_sel ? r_rd1_b : r_rd0_b;
    assign o_older  = r_sel ? r_rd0_a : r_rd1_a;

endmodule

@@ rtl/heightmap_neighbour_smoother_top.sv @@
// Four-neighbour smoother for a square height grid streamed in raster order. One
// sample word is taken per cycle while o_in_ready is high; the result for cell (r-1, c)
// leaves with input (r, c), so row 0 gives no results and rows 1 to side-2 give one
// result per word. Words of the last row give two results (its first word one, its
// final word three), and since at most one result leaves per cycle the input is held
// back there. A word passes the stage 1 and stage 2 registers into a four-entry result
// queue, which sets how far input runs ahead of a stalled output. Two row stores of
// MAX_SIDE words keep the previous and older rows and swap at each row end; they need
// no clearing after reset. Writing grid_side restarts the frame.
`include "heightmap_neighbour_smoother_top_macros.svh"

module heightmap_neighbour_smoother_top
    import hns_pkg::*;
#(
    parameter int MAX_SIDE    = 1024,
    parameter int HEIGHT_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [HEIGHT_BITS-1:0] i_height_in,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [HEIGHT_BITS-1:0] o_height_out,
    output logic [POS_W-1:0]              o_out_row,
    output logic [POS_W-1:0]              o_out_col,
    output logic                          o_run_last,
    output logic                          o_frame_done,
    input  logic                          i_cfg_wr_en,
    input  logic [CFG_W-1:0]              i_cfg_wr_data
);

    localparam int CW     = $clog2(MAX_SIDE);
    localparam int HB     = HEIGHT_BITS;
    localparam int SW     = HEIGHT_BITS + 2;
    localparam int K      = SW + 1;
    localparam int FDEPTH = 4;
    localparam int PW     = $clog2(FDEPTH);
    localparam longint unsigned RECIP3_L = ((64'd1 << K) + 64'd2) / 64'd3;
    localparam logic [SW-1:0]   RECIP3   = SW'(RECIP3_L);
    localparam int              RST_SIDE = (RESET_SIDE > MAX_SIDE) ? MAX_SIDE : RESET_SIDE;
    localparam logic [CW-1:0]   RST_LAST = CW'(RST_SIDE - 1);

    typedef struct packed {
        logic [HB-1:0] q0;
        logic [HB-1:0] q1;
        logic [HB-1:0] q2;
        logic [CW-1:0] row;
        logic [CW-1:0] col;
        logic          has2;
        logic          has3;
    } t_entry;

    // signed sum divided by 2, 3 or 4, truncated toward zero
    function automatic logic [HB-1:0] f_avg(input logic [SW-1:0] sum, input t_div div);
        logic [SW-1:0]   mag;
        logic [2*SW-1:0] prod;
        logic [HB-1:0]   q;
        mag  = sum[SW-1] ? (~sum + 1'b1) : sum;
        prod = (2*SW)'(mag) * (2*SW)'(RECIP3);
        case (div)
            DIV2:    q = mag[1 +: HB];
            DIV4:    q = mag[2 +: HB];
            default: q = prod[K +: HB];
        endcase
        f_avg = sum[SW-1] ? (~q + 1'b1) : q;
    endfunction

    // position and config
    logic [CW-1:0] r_last, r_row, r_col, cfg_last;
    logic          acc, col_end, row_end, has1;
    t_nbr          nbr;
    logic [CW-1:0] addr_a, addr_b;
    logic [HB-1:0] prev_a, prev_b, older;

    // stage 1
    logic          r_s1_v;
    logic [HB-1:0] r_s1_x, r_s1_h1, r_s1_h2;
    logic [CW-1:0] r_s1_row, r_s1_col;
    t_nbr          r_s1_nbr;
    logic [SW-1:0] ext_x, ext_h1, ext_h2, ext_pa, ext_pb, ext_old;
    logic [SW-1:0] sum0, sum1, sum2;
    t_div          div0, div1;
    logic [1:0]    cnt0;

    // stage 2
    logic          r_s2_v;
    logic [SW-1:0] r_s2_sum0, r_s2_sum1, r_s2_sum2;
    t_div          r_s2_div0, r_s2_div1;
    logic [CW-1:0] r_s2_row, r_s2_col;
    logic          r_s2_has2, r_s2_has3;
    t_entry        entry_in;

    // result queue
    t_entry        r_fifo [FDEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [PW:0]   r_fifo_cnt, n_fifo_cnt;
    logic [PW:0]   r_credit, n_credit;
    t_lane         r_lane;
    t_entry        head;
    logic          lane_last, pop, pop_entry;

    always_comb begin
        if (int'(i_cfg_wr_data) < 2) begin
            cfg_last = CW'(1);
        end else if (int'(i_cfg_wr_data) > MAX_SIDE) begin
            cfg_last = CW'(MAX_SIDE - 1);
        end else begin
            cfg_last = CW'(int'(i_cfg_wr_data) - 1);
        end
    end

    assign col_end = (r_col == r_last);
    assign row_end = (r_row == r_last);
    assign has1    = (r_row != '0);

    assign nbr.up    = (r_row > CW'(1));
    assign nbr.left  = (r_col != '0);
    assign nbr.right = !col_end;
    assign nbr.left2 = (r_col > CW'(1));
    assign nbr.has2  = row_end && (r_col != '0);
    assign nbr.has3  = row_end && col_end;

    // only words that produce results need a queue slot
    assign o_in_ready = !has1 || (r_credit < (PW+1)'(FDEPTH));
    assign acc        = i_in_valid && o_in_ready;

    assign addr_a = (r_col == '0) ? '0 : r_col - 1'b1;
    assign addr_b = col_end ? r_col : r_col + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= RST_LAST;
            r_row  <= '0;
            r_col  <= '0;
        end else if (i_cfg_wr_en) begin
            r_last <= cfg_last;
            r_row  <= '0;
            r_col  <= '0;
        end else if (acc) begin
            if (col_end) begin
                r_col <= '0;
                r_row <= row_end ? '0 : r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    hns_linebuf #(
        .DEPTH (MAX_SIDE),
        .WIDTH (HEIGHT_BITS)
    ) u_linebuf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (acc),
        .i_swap   (col_end),
        .i_col    (r_col),
        .i_addr_a (addr_a),
        .i_addr_b (addr_b),
        .i_wdata  (i_height_in),
        .o_prev_a (prev_a),
        .o_prev_b (prev_b),
        .o_older  (older)
    );

    // stage 1: word, two earlier words of the row, row store reads
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= acc && has1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_x   <= i_height_in;
            r_s1_h1  <= r_s1_x;
            r_s1_h2  <= r_s1_h1;
            r_s1_row <= r_row;
            r_s1_col <= r_col;
            r_s1_nbr <= nbr;
        end
    end

    assign ext_x   = SW'($signed(r_s1_x));
    assign ext_h1  = SW'($signed(r_s1_h1));
    assign ext_h2  = SW'($signed(r_s1_h2));
    assign ext_pa  = SW'($signed(prev_a));
    assign ext_pb  = SW'($signed(prev_b));
    assign ext_old = SW'($signed(older));

    // cell above the word, left cell of last row, final cell
    assign sum0 = ext_x + (r_s1_nbr.up ? ext_old : '0)
                + (r_s1_nbr.left ? ext_pa : '0) + (r_s1_nbr.right ? ext_pb : '0);
    assign sum1 = ext_x + ext_pa + (r_s1_nbr.left2 ? ext_h2 : '0);
    assign sum2 = ext_pb + ext_h1;

    assign cnt0 = 2'(r_s1_nbr.up) + 2'(r_s1_nbr.left) + 2'(r_s1_nbr.right);

    always_comb begin
        case (cnt0)
            2'd1:    div0 = DIV2;
            2'd2:    div0 = DIV3;
            default: div0 = DIV4;
        endcase
        div1 = r_s1_nbr.left2 ? DIV3 : DIV2;
    end

    // stage 2: sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_v) begin
            r_s2_sum0 <= sum0;
            r_s2_sum1 <= sum1;
            r_s2_sum2 <= sum2;
            r_s2_div0 <= div0;
            r_s2_div1 <= div1;
            r_s2_row  <= r_s1_row;
            r_s2_col  <= r_s1_col;
            r_s2_has2 <= r_s1_nbr.has2;
            r_s2_has3 <= r_s1_nbr.has3;
        end
    end

    assign entry_in.q0   = f_avg(r_s2_sum0, r_s2_div0);
    assign entry_in.q1   = f_avg(r_s2_sum1, r_s2_div1);
    assign entry_in.q2   = f_avg(r_s2_sum2, DIV2);
    assign entry_in.row  = r_s2_row;
    assign entry_in.col  = r_s2_col;
    assign entry_in.has2 = r_s2_has2;
    assign entry_in.has3 = r_s2_has3;

    // result queue, one entry per result-producing word, results leave one per cycle while the receiver is ready
    always_ff @(posedge i_clk) begin
        if (r_s2_v) begin
            r_fifo[r_wp] <= entry_in;
        end
    end

    assign head        = r_fifo[r_rp];
    assign o_out_valid = (r_fifo_cnt != '0);
    assign pop         = o_out_valid && i_out_ready;
    assign pop_entry   = pop && lane_last;

    always_comb begin
        unique case (r_lane)
            LANE_PREV: lane_last = !head.has2;
            LANE_LEFT: lane_last = !head.has3;
            default:   lane_last = 1'b1;
        endcase
    end

    assign n_fifo_cnt = r_fifo_cnt + (PW+1)'(r_s2_v) - (PW+1)'(pop_entry);
    assign n_credit   = r_credit + (PW+1)'(acc && has1) - (PW+1)'(pop_entry);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp       <= '0;
            r_rp       <= '0;
            r_fifo_cnt <= '0;
            r_credit   <= '0;
            r_lane     <= LANE_PREV;
        end else begin
            r_fifo_cnt <= n_fifo_cnt;
            r_credit   <= n_credit;
            if (r_s2_v) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                if (lane_last) begin
                    r_lane <= LANE_PREV;
                    r_rp   <= r_rp + 1'b1;
                end else begin
                    unique case (r_lane)
                        LANE_PREV: r_lane <= LANE_LEFT;
                        LANE_LEFT: r_lane <= LANE_FINAL;
                        default:   r_lane <= LANE_PREV;
                    endcase
                end
            end
        end
    end

    always_comb begin
        case (r_lane)
            LANE_LEFT: begin
                o_height_out = $signed(head.q1);
                o_out_row    = POS_W'(head.row);
                o_out_col    = POS_W'(head.col - 1'b1);
            end
            LANE_FINAL: begin
                o_height_out = $signed(head.q2);
                o_out_row    = POS_W'(head.row);
                o_out_col    = POS_W'(head.col);
            end
            default: begin
                o_height_out = $signed(head.q0);
                o_out_row    = POS_W'(head.row - 1'b1);
                o_out_col    = POS_W'(head.col);
            end
        endcase
    end

    assign o_run_last   = lane_last;
    assign o_frame_done = (r_lane == LANE_FINAL);

    `HNS_ASSERT_IMP(a_credit_track, i_clk, i_rst_n, 1'b1, r_credit == r_fifo_cnt + (PW+1)'(r_s1_v) + (PW+1)'(r_s2_v))
    `HNS_ASSERT_IMP(a_fifo_room, i_clk, i_rst_n, r_s2_v, r_fifo_cnt < (PW+1)'(FDEPTH))
    `HNS_ASSERT_NEXT(a_frame_wrap, i_clk, i_rst_n, acc && row_end && col_end, r_row == '0 && r_col == '0)
    `HNS_ASSERT_IMP(a_final_closes, i_clk, i_rst_n, o_out_valid && o_frame_done, o_run_last)

endmodule

@@ test/heightmap_neighbour_smoother_top_tb.sv @@
module heightmap_neighbour_smoother_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hns_pkg::*;

    localparam int MAX_SIDE    = 1024;
    localparam int HEIGHT_BITS = 24;
    localparam int STALL_LIMIT = 5000;
    localparam int SETTLE      = 12;
    localparam int SHOW_MAX    = 10;

    localparam logic signed [HEIGHT_BITS-1:0] H_MAX = {1'b0, {(HEIGHT_BITS-1){1'b1}}};
    localparam logic signed [HEIGHT_BITS-1:0] H_MIN = {1'b1, {(HEIGHT_BITS-1){1'b0}}};

    typedef struct {
        logic signed [HEIGHT_BITS-1:0] height;
        logic [POS_W-1:0]              row;
        logic [POS_W-1:0]              col;
        logic                          run_last;
        logic                          frame_done;
    } t_cell_result;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_ready;
    logic signed [HEIGHT_BITS-1:0] i_height_in;
    logic                          o_out_valid;
    logic                          i_out_ready;
    logic signed [HEIGHT_BITS-1:0] o_height_out;
    logic [POS_W-1:0]              o_out_row;
    logic [POS_W-1:0]              o_out_col;
    logic                          o_run_last;
    logic                          o_frame_done;
    logic                          i_cfg_wr_en;
    logic [CFG_W-1:0]              i_cfg_wr_data;

    heightmap_neighbour_smoother_top #(
        .MAX_SIDE    (MAX_SIDE),
        .HEIGHT_BITS (HEIGHT_BITS)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_height_in   (i_height_in),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_height_out  (o_height_out),
        .o_out_row     (o_out_row),
        .o_out_col     (o_out_col),
        .o_run_last    (o_run_last),
        .o_frame_done  (o_frame_done),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    // smoother state mirrored on the testbench side
    logic [CFG_W-1:0]              side_reg;
    logic signed [HEIGHT_BITS-1:0] row_store [2][MAX_SIDE];
    bit                            cur_bank;
    logic signed [HEIGHT_BITS-1:0] held_left;
    int unsigned                   row_pos;
    int unsigned                   col_pos;

    t_cell_result smoothed_q[$];

    int  words_sent;
    int  cells_checked;
    int  frames_seen;
    int  side_writes;
    int  mismatch_count;
    bit  src_gaps_on;
    bit  sink_gaps_on;
    int  sink_hold_req;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 6) == 0)
            return $urandom_range(8, 30);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic signed [HEIGHT_BITS-1:0] pick_height();
        case ($urandom_range(0, 9))
            0: return H_MAX;
            1: return H_MIN;
            2: return HEIGHT_BITS'($urandom_range(0, 7)) - HEIGHT_BITS'(4);
            default: return HEIGHT_BITS'($urandom);
        endcase
    endfunction

    function automatic t_cell_result make_cell(longint sum, longint cnt, int unsigned row,
                                               int unsigned col, bit done);
        t_cell_result res;
        res.height     = HEIGHT_BITS'(sum / cnt);
        res.row        = row[POS_W-1:0];
        res.col        = col[POS_W-1:0];
        res.run_last   = 1'b0;
        res.frame_done = done;
        return res;
    endfunction

    task automatic smooth_predict(input logic signed [HEIGHT_BITS-1:0] h);
        int unsigned  s, r, c;
        longint       sum, cnt;
        int           n;
        t_cell_result cells[3];
        s = 32'(side_reg);
        if (s < 2) s = 2;
        if (s > MAX_SIDE) s = MAX_SIDE;
        r = row_pos;
        c = col_pos;
        n = 0;
        if (r >= s || c >= s) begin
            r = 0;
            c = 0;
        end
        // cell one row up, now that its lower neighbour is known
        if (r >= 1) begin
            sum = longint'(h);
            cnt = 1;
            if (r >= 2) begin
                sum += longint'(row_store[!cur_bank][c]);
                cnt++;
            end
            if (c > 0) begin
                sum += longint'(row_store[cur_bank][c-1]);
                cnt++;
            end
            if (c + 1 < s) begin
                sum += longint'(row_store[cur_bank][c+1]);
                cnt++;
            end
            cells[n] = make_cell(sum, cnt, r - 1, c, 1'b0);
            n++;
        end
        // last row: left cell has no lower neighbour
        if (r == s - 1 && c >= 1) begin
            sum = longint'(h);
            sum += longint'(row_store[cur_bank][c-1]);
            cnt = 2;
            if (c >= 2) begin
                sum += longint'(row_store[!cur_bank][c-2]);
                cnt++;
            end
            cells[n] = make_cell(sum, cnt, r, c - 1, 1'b0);
            n++;
        end
        if (r == s - 1 && c == s - 1) begin
            sum = longint'(row_store[cur_bank][c]);
            sum += longint'(held_left);
            cells[n] = make_cell(sum, 2, r, c, 1'b1);
            n++;
        end
        row_store[!cur_bank][c] = h;
        held_left = h;
        c++;
        if (c >= s) begin
            cur_bank = !cur_bank;
            c = 0;
            r++;
            if (r >= s) r = 0;
        end
        row_pos = r;
        col_pos = c;
        if (n > 0) cells[n-1].run_last = 1'b1;
        for (int k = 0; k < n; k++)
            smoothed_q.push_back(cells[k]);
    endtask

    task automatic send_height(input logic signed [HEIGHT_BITS-1:0] h);
        int gap;
        gap = 0;
        if (src_gaps_on && $urandom_range(0, 3) == 0)
            gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_height_in <= h;
        do @(posedge i_clk); while (!o_in_ready);
        smooth_predict(h);
        words_sent++;
    endtask

    task automatic send_random(input int count);
        repeat (count) send_height(pick_height());
    endtask

    task automatic stop_sending();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (smoothed_q.size() != 0) @(posedge i_clk);
        // row 0 words leave nothing behind, give them time to settle
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_side(input logic [CFG_W-1:0] value);
        stop_sending();
        wait_drained();
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        side_reg = value;
        row_pos  = 0;
        col_pos  = 0;
        side_writes++;
    endtask

    // default side after reset, partial row 0 then a restart by register write
    task automatic test_reset_side();
        send_random(6);
    endtask

    task automatic test_small_sides();
        logic signed [HEIGHT_BITS-1:0] vals9[9];
        // below range acts as side 2
        write_side(CFG_W'(0));
        send_height(H_MAX);
        send_height(H_MIN);
        send_height(H_MIN);
        send_height(H_MAX);
        // next frame follows with no write
        repeat (4) send_height(H_MAX);
        write_side(CFG_W'(1));
        send_height(HEIGHT_BITS'(-1));
        send_height(HEIGHT_BITS'(-2));
        send_height(HEIGHT_BITS'(-3));
        send_height(HEIGHT_BITS'(0));
        write_side(CFG_W'(3));
        vals9 = '{H_MAX, H_MIN, HEIGHT_BITS'(-1), H_MIN, H_MAX, HEIGHT_BITS'(1),
                  HEIGHT_BITS'(-2), H_MAX, H_MIN};
        foreach (vals9[i]) send_height(vals9[i]);
    endtask

    // widest side and sides above range that clamp to it; a few row 0 words each
    task automatic test_widest_grid();
        write_side(CFG_W'(MAX_SIDE));
        send_random(4);
        write_side({CFG_W{1'b1}});
        send_random(2);
        write_side(CFG_W'(MAX_SIDE + 1));
        send_random(2);
    endtask

    // receiver holds off while words keep coming, so the block fills and stalls
    task automatic test_output_backpressure();
        write_side(CFG_W'(6));
        src_gaps_on   = 1'b0;
        sink_hold_req = 150;
        send_random(36);
        src_gaps_on = 1'b1;
    endtask

    task automatic test_random_frames();
        int          start;
        int unsigned side, eff;
        start = words_sent;
        while (words_sent - start < 30) begin
            if ($urandom_range(0, 7) == 0)
                side = $urandom_range(0, 1);
            else
                side = $urandom_range(2, 5);
            write_side(CFG_W'(side));
            eff = (side < 2) ? 2 : side;
            src_gaps_on  = ($urandom_range(0, 3) != 0);
            sink_gaps_on = ($urandom_range(0, 3) != 0);
            send_random(int'(eff * eff));
            // broken frame, cut short by the next register write
            if ($urandom_range(0, 4) == 0)
                send_random(int'($urandom_range(1, eff * eff - 1)));
        end
        stop_sending();
        src_gaps_on  = 1'b1;
        sink_gaps_on = 1'b1;
    endtask

    // receiver side ready
    initial begin
        int stall_left;
        stall_left  = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_hold_req > 0) begin
                stall_left    = sink_hold_req;
                sink_hold_req = 0;
            end else if (stall_left == 0 && sink_gaps_on && $urandom_range(0, 4) == 0) begin
                stall_left = pick_gap();
            end
            if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_cell_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            cells_checked++;
            if (o_frame_done) frames_seen++;
            if (smoothed_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= SHOW_MAX)
                    $display("unexpected word: height %0d row %0d col %0d",
                             o_height_out, o_out_row, o_out_col);
            end else begin
                want = smoothed_q.pop_front();
                if (o_height_out !== want.height || o_out_row !== want.row ||
                    o_out_col !== want.col || o_run_last !== want.run_last ||
                    o_frame_done !== want.frame_done) begin
                    mismatch_count++;
                    if (mismatch_count <= SHOW_MAX)
                        $display({"mismatch: expected h=%0d r=%0d c=%0d last=%0b done=%0b,",
                                  " got h=%0d r=%0d c=%0d last=%0b done=%0b"},
                                 want.height, want.row, want.col, want.run_last,
                                 want.frame_done, o_height_out, o_out_row, o_out_col,
                                 o_run_last, o_frame_done);
                end
            end
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no handshake for %0d cycles, %0d cells still pending",
                 STALL_LIMIT, smoothed_q.size());
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_height_in    = '0;
        i_cfg_wr_en    = 1'b0;
        i_cfg_wr_data  = '0;
        side_reg       = CFG_W'(RESET_SIDE);
        cur_bank       = 1'b0;
        held_left      = '0;
        row_pos        = 0;
        col_pos        = 0;
        words_sent     = 0;
        cells_checked  = 0;
        frames_seen    = 0;
        side_writes    = 0;
        mismatch_count = 0;
        src_gaps_on    = 1'b1;
        sink_gaps_on   = 1'b1;
        sink_hold_req  = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_side();
        test_small_sides();
        test_widest_grid();
        test_output_backpressure();
        test_random_frames();

        stop_sending();
        wait_drained();
        $display("sent %0d height words over %0d side settings (2 up to %0d, clamped values too)",
                 words_sent, side_writes, MAX_SIDE);
        $display("checked %0d smoothed cells, %0d complete frames, %0d mismatches",
                 cells_checked, frames_seen, mismatch_count);
        if (mismatch_count == 0 && smoothed_q.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

@@ heightmap_neighbour_smoother_top.f @@
+incdir+rtl
rtl/hns_pkg.sv
rtl/hns_linebuf.sv
rtl/heightmap_neighbour_smoother_top.sv
test/heightmap_neighbour_smoother_top_tb.sv
